// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the interrupt controller checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("interrupt controller check failed");

// Next-cycle implication, disabled while reset is low.
`define PIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("interrupt controller check failed");

`endif

// ----- rtl/core/pic_pkg.sv -----
// Types, codes and helpers of the priority interrupt controller.
`default_nettype none
package pic_pkg;

	localparam int LINES  = 8;
	localparam int LINE_W = 3;

	localparam int S_DATA_W = 16;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 2;

	// Item kinds carried in s_axis_tuser.
	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_IRQ   = 3'd2;
	localparam logic [2:0] REQ_ACK   = 3'd3;
	localparam logic [2:0] REQ_CHECK = 3'd4;

	// Command word codes in bits 7..5.
	localparam logic [2:0] CMD_EOI      = 3'd1;
	localparam logic [2:0] CMD_SEOI     = 3'd3;
	localparam logic [2:0] CMD_ROT_EOI  = 3'd5;
	localparam logic [2:0] CMD_SET_PRI  = 3'd6;
	localparam logic [2:0] CMD_ROT_SEOI = 3'd7;

	// Bit positions inside written bytes.
	localparam int B_ICW1   = 4;
	localparam int B_OCW3   = 3;
	localparam int B_POLL   = 2;
	localparam int B_RR     = 1;
	localparam int B_RIS    = 0;
	localparam int B_SNGL   = 1;
	localparam int B_ADI    = 2;

	localparam logic [1:0]        STEP_VECTOR = 2'd2;
	localparam logic [1:0]        STEP_LAST   = 2'd1;
	localparam logic [LINE_W-1:0] PRI_RESET   = 3'd7;
	localparam logic [7:0]        POLL_FLAG   = 8'h80;

	// Update commands for one cell.
	typedef struct packed {
		logic set_req;
		logic clr_req;
		logic set_isr;
		logic clr_isr;
		logic clr_all_isr;
		logic mask_we;
		logic mask_val;
	} cell_cmd_t;

	// Carries handed from cell to cell, one pair per search.
	typedef struct packed {
		logic any_srv;
		logic up_srv;
		logic any_isr;
		logic up_isr;
		logic any_req;
		logic up_req;
	} chain_t;

	// Winner flags of the three searches.
	typedef struct packed {
		logic srv;
		logic isr;
		logic req;
	} hit_t;

	// Stored bits of one line.
	typedef struct packed {
		logic req;
		logic isr;
		logic mask;
	} cell_bits_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              vector_valid;
		logic [15:0]       vector;
		logic              pending_valid;
		logic [LINE_W-1:0] pending_line;
	} result_t;

	function automatic logic [LINE_W-1:0] onehot_idx(input logic [LINES-1:0] oh);
		logic [LINE_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < LINES; i++) begin
			if (oh[i]) begin
				idx = idx | LINE_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [LINES-1:0] line_dec(input logic [LINE_W-1:0] ln);
		return LINES'(1) << ln;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pic_cell.sv -----
// One interrupt line: request, in-service and mask bits plus its link of the priority chain.
`default_nettype none
module pic_cell (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic [pic_pkg::LINE_W-1:0]  index,
	input  wire logic [pic_pkg::LINE_W-1:0]  start,
	input  wire pic_pkg::cell_cmd_t          cmd,
	input  wire pic_pkg::chain_t             chain_in,
	input  wire pic_pkg::chain_t             chain_end,
	output pic_pkg::chain_t                  chain_out,
	output pic_pkg::hit_t                    hit,
	output pic_pkg::cell_bits_t              bits
);
	import pic_pkg::*;

	logic req_q;
	logic isr_q;
	logic mask_q;
	logic ge;
	logic srv_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q  <= 1'b0;
			isr_q  <= 1'b0;
			mask_q <= 1'b1;
		end else begin
			if (cmd.set_req) begin
				req_q <= 1'b1;
			end else if (cmd.clr_req) begin
				req_q <= 1'b0;
			end
			if (cmd.clr_all_isr) begin
				isr_q <= 1'b0;
			end else if (cmd.set_isr) begin
				isr_q <= 1'b1;
			end else if (cmd.clr_isr) begin
				isr_q <= 1'b0;
			end
			if (cmd.mask_we) begin
				mask_q <= cmd.mask_val;
			end
		end
	end

	// Lines at or above the start point win first; lower lines only on wrap.
	assign ge      = (index >= start);
	assign srv_bit = (req_q & ~mask_q) | isr_q;

	always_comb begin
		chain_out.any_srv = chain_in.any_srv | srv_bit;
		chain_out.up_srv  = chain_in.up_srv | (srv_bit & ge);
		chain_out.any_isr = chain_in.any_isr | isr_q;
		chain_out.up_isr  = chain_in.up_isr | (isr_q & ge);
		chain_out.any_req = chain_in.any_req | req_q;
		chain_out.up_req  = chain_in.up_req | (req_q & ge);
	end

	// The chain end comes back from the last cell, so keep it apart from the carry logic.
	always_comb begin
		hit.srv = srv_bit & (ge ? ~chain_in.up_srv : (~chain_end.up_srv & ~chain_in.any_srv));
		hit.isr = isr_q & (ge ? ~chain_in.up_isr : (~chain_end.up_isr & ~chain_in.any_isr));
		hit.req = req_q & (ge ? ~chain_in.up_req : (~chain_end.up_req & ~chain_in.any_req));
	end

	assign bits = '{req: req_q, isr: isr_q, mask: mask_q};

endmodule
`default_nettype wire

// ----- rtl/core/priority_interrupt_controller.sv -----
// Top level of the 8-line rotating-priority interrupt controller.
//
// Eight-line interrupt controller in the 8259 style, set up for 8080 call
// vectors. Every input word is one event, coded in s_axis_tuser: a bus write,
// a bus read, a raised interrupt line, an acknowledge or a pending check; each
// accepted word yields exactly one output word. The request, in-service and
// mask bits live in a row of eight line cells; the rotating priority search
// runs as a carry chain through that row, starting at the line after the
// lowest-priority one and wrapping once. Each item is decoded, searched and
// its result registered in the cycle it is accepted, so words can enter back
// to back while the buffer has room; the eight-cell priority chain sets the
// clock path. Results wait in a two-entry output buffer, so one more word is
// taken while a result is stalled; s_axis_tready drops only when both entries
// are full. After reset all lines are masked and the vector high byte is zero.
`default_nettype none
module priority_interrupt_controller (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// addr_bit [0], write_data [8:1], irq_line [11:9], zero pad [15:12]
	input  wire logic [pic_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// req_type [2:0]
	input  wire logic [pic_pkg::S_USER_W-1:0]  s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// read_data [7:0], vector [23:8], pending_line [26:24], zero pad [31:27]
	output logic [pic_pkg::M_DATA_W-1:0]       m_axis_tdata,
	// vector_valid [0], pending_valid [1]
	output logic [pic_pkg::M_USER_W-1:0]       m_axis_tuser
);
	import pic_pkg::*;

	// Input word fields.
	logic [2:0]        req_type;
	logic              addr_bit;
	logic [7:0]        write_data;
	logic [LINE_W-1:0] irq_line;

	assign req_type   = s_axis_tuser;
	assign addr_bit   = s_axis_tdata[0];
	assign write_data = s_axis_tdata[8:1];
	assign irq_line   = s_axis_tdata[11:9];

	// Controller state.
	logic [7:0]        icw1_q;
	logic [7:0]        vector_high_q;
	logic              init_active_q;
	logic [1:0]        init_step_q;
	logic [LINE_W-1:0] lowest_q;
	logic              read_req_q;
	logic              poll_q;

	// Output buffer.
	result_t out_q;
	result_t skid_q;
	logic    out_vld_q;
	logic    skid_vld_q;

	logic acc;
	assign s_axis_tready = ~skid_vld_q;
	assign acc           = s_axis_tvalid & ~skid_vld_q;

	// Decoded event kinds.
	logic is_write;
	logic is_read;
	logic is_irq;
	logic is_ack;
	logic is_check;
	logic wr_icw1;
	logic wr_ocw3;
	logic wr_ocw2;
	logic wr_odd;
	logic [2:0] ocw2_code;

	always_comb begin
		is_write = 1'b0;
		is_read  = 1'b0;
		is_irq   = 1'b0;
		is_ack   = 1'b0;
		is_check = 1'b0;
		unique case (req_type)
			REQ_WRITE: is_write = 1'b1;
			REQ_READ:  is_read  = 1'b1;
			REQ_IRQ:   is_irq   = 1'b1;
			REQ_ACK:   is_ack   = 1'b1;
			REQ_CHECK: is_check = 1'b1;
			default: begin
				// Unknown kinds leave everything alone and return zeros.
			end
		endcase
	end

	assign ocw2_code = write_data[7:5];
	assign wr_odd    = acc & is_write & addr_bit;
	assign wr_icw1   = acc & is_write & ~addr_bit & write_data[B_ICW1];
	assign wr_ocw3   = acc & is_write & ~addr_bit & ~write_data[B_ICW1] & write_data[B_OCW3];
	assign wr_ocw2   = acc & is_write & ~addr_bit & ~write_data[B_ICW1] & ~write_data[B_OCW3];

	// Row of line cells with the priority chain.
	cell_cmd_t  cmd   [LINES];
	chain_t     chain [LINES+1];
	hit_t       hit   [LINES];
	cell_bits_t bits  [LINES];

	logic [LINE_W-1:0] start;
	assign start    = lowest_q + LINE_W'(1);
	assign chain[0] = '0;

	logic [LINES-1:0] hit_srv;
	logic [LINES-1:0] hit_isr;
	logic [LINES-1:0] hit_req;
	logic [LINES-1:0] req_v;
	logic [LINES-1:0] isr_v;
	logic [LINES-1:0] mask_v;

	for (genvar g = 0; g < LINES; g++) begin : g_cell
		pic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (LINE_W'(g)),
			.start     (start),
			.cmd       (cmd[g]),
			.chain_in  (chain[g]),
			.chain_end (chain[LINES]),
			.chain_out (chain[g+1]),
			.hit       (hit[g]),
			.bits      (bits[g])
		);
		assign hit_srv[g] = hit[g].srv;
		assign hit_isr[g] = hit[g].isr;
		assign hit_req[g] = hit[g].req;
		assign req_v[g]   = bits[g].req;
		assign isr_v[g]   = bits[g].isr;
		assign mask_v[g]  = bits[g].mask;
	end

	// Serve test: the winner must beat the highest line already in service.
	logic              serve_ok;
	logic [LINE_W-1:0] serve_line;
	logic [LINE_W-1:0] isr_top;
	logic [LINE_W-1:0] req_top;

	assign serve_ok   = (|hit_srv) & (hit_srv != hit_isr);
	assign serve_line = onehot_idx(hit_srv);
	assign isr_top    = onehot_idx(hit_isr);
	assign req_top    = onehot_idx(hit_req);

	// Per-line updates.
	logic [LINES-1:0] set_req_v;
	logic [LINES-1:0] served_v;
	logic [LINES-1:0] clr_isr_v;
	logic             mask_we;
	logic [7:0]       mask_val;

	always_comb begin
		set_req_v = (acc & is_irq) ? line_dec(irq_line) : '0;
		served_v  = (acc & is_ack & serve_ok) ? hit_srv : '0;
		clr_isr_v = '0;
		if (wr_ocw2) begin
			unique case (ocw2_code)
				CMD_EOI, CMD_ROT_EOI:  clr_isr_v = hit_isr;
				CMD_SEOI, CMD_ROT_SEOI: clr_isr_v = line_dec(write_data[LINE_W-1:0]);
				default:                clr_isr_v = '0;
			endcase
		end
		mask_we  = wr_icw1 | (wr_odd & ~init_active_q);
		mask_val = wr_icw1 ? 8'h00 : write_data;
		for (int i = 0; i < LINES; i++) begin
			cmd[i].set_req     = set_req_v[i];
			cmd[i].clr_req     = served_v[i];
			cmd[i].set_isr     = served_v[i];
			cmd[i].clr_isr     = clr_isr_v[i];
			cmd[i].clr_all_isr = wr_icw1;
			cmd[i].mask_we     = mask_we;
			cmd[i].mask_val    = mask_val[i];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icw1_q        <= '0;
			vector_high_q <= '0;
			init_active_q <= 1'b0;
			init_step_q   <= '0;
			lowest_q      <= PRI_RESET;
			read_req_q    <= 1'b0;
			poll_q        <= 1'b0;
		end else begin
			if (wr_odd && init_active_q) begin
				// Init data: step two loads the vector, step one only ends init, step zero does both.
				if (init_step_q == STEP_VECTOR) begin
					vector_high_q <= write_data;
				end else if (init_step_q == STEP_LAST) begin
					init_active_q <= 1'b0;
				end else begin
					vector_high_q <= write_data;
					init_active_q <= 1'b0;
				end
				if (init_step_q != 2'd0) begin
					init_step_q <= init_step_q - 2'd1;
				end
			end
			if (wr_icw1) begin
				init_active_q <= 1'b1;
				icw1_q        <= write_data;
				lowest_q      <= PRI_RESET;
				poll_q        <= 1'b0;
				read_req_q    <= 1'b0;
				if (!write_data[B_SNGL]) begin
					init_step_q <= STEP_VECTOR;
				end
			end
			if (wr_ocw3) begin
				if (write_data[B_RR]) begin
					read_req_q <= ~write_data[B_RIS];
				end
				if (write_data[B_POLL]) begin
					poll_q <= 1'b1;
				end
			end
			if (wr_ocw2) begin
				unique case (ocw2_code)
					CMD_EOI, CMD_SEOI: lowest_q <= PRI_RESET;
					CMD_ROT_EOI: begin
						if (|isr_v) begin
							lowest_q <= isr_top;
						end
					end
					CMD_SET_PRI, CMD_ROT_SEOI: lowest_q <= write_data[LINE_W-1:0];
					default: begin
						// Codes without effect.
					end
				endcase
			end
			// A poll read disarms poll.
			if (acc && is_read && !addr_bit && poll_q) begin
				poll_q <= 1'b0;
			end
		end
	end

	// Result of the accepted word.
	result_t res;
	logic [7:0] vec_low;

	always_comb begin
		if (icw1_q[B_ADI]) begin
			vec_low = {icw1_q[7:5], serve_line, 2'b00};
		end else begin
			vec_low = {icw1_q[7:6], serve_line, 3'b000};
		end
		res = '0;
		if (is_read) begin
			if (addr_bit) begin
				res.read_data = mask_v;
			end else if (poll_q) begin
				res.read_data = (|req_v) ? (POLL_FLAG | 8'(req_top)) : 8'(start);
			end else begin
				res.read_data = read_req_q ? req_v : isr_v;
			end
		end
		if (is_ack && serve_ok) begin
			res.vector_valid = 1'b1;
			res.vector       = {vector_high_q, vec_low};
		end
		if (is_check && serve_ok) begin
			res.pending_valid = 1'b1;
			res.pending_line  = serve_line;
		end
	end

	// Two-entry output buffer: hold in skid while the output entry stalls.
	logic pop;
	assign pop = out_vld_q & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || pop) begin
				out_vld_q  <= skid_vld_q | acc;
				skid_vld_q <= 1'b0;
			end else if (acc) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_q.pending_line, out_q.vector, out_q.read_data};
	assign m_axis_tuser  = {out_q.pending_valid, out_q.vector_valid};

endmodule
`default_nettype wire

// ----- rtl/core/pic_checker.sv -----
// Port-level checks of the interrupt controller and their bind.
`default_nettype none
`include "assert_macros.svh"
module pic_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                s_axis_tvalid,
	input wire                                s_axis_tready,
	input wire                                m_axis_tvalid,
	input wire                                m_axis_tready,
	input wire logic [pic_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input wire logic [pic_pkg::M_USER_W-1:0]  m_axis_tuser
);
	// After an accepted word the output is valid next cycle, though the word may wait in skid.
	`PIC_ASSERT_NEXT(a_accept_fills, clk, arst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
	// Input stalls only while a result is waiting.
	`PIC_ASSERT_NOW(a_stall_when_full, clk, arst_n, !s_axis_tready, m_axis_tvalid)
	// A word never carries both a vector and a pending line.
	`PIC_ASSERT_NOW(a_one_kind, clk, arst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
	// Without a served line the vector field stays zero.
	`PIC_ASSERT_NOW(a_vector_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[23:8] == 16'h0000)
endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (.*);
`default_nettype wire
